>>> design/wsa_pkg.sv
// wsa_pkg: shared types, field widths and codes for the watchpoint slot allocator
// depends on nothing; used by the channel interfaces and the top level

package wsa_pkg;

  // transaction field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;

  // command codes
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_CHECK = 2'd2;

  // result status codes
  localparam status_t ST_DONE       = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_BAD_VALUE  = 3'd2;
  localparam status_t ST_NOT_ACTIVE = 3'd3;
  localparam status_t ST_CHANGED    = 3'd4;
  localparam status_t ST_NO_EVAL    = 3'd5;

endpackage

>>> design/wsa_if.sv
// wsa_in_if / wsa_out_if: valid/ready channels for commands and results
// depends on wsa_pkg for field types

interface wsa_in_if;
  import wsa_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  slot_t  entry_number;
  value_t new_value;
  logic   value_ok;

  modport source (output valid, command, entry_number, new_value, value_ok, input ready);
  modport sink   (input valid, command, entry_number, new_value, value_ok, output ready);
endinterface

interface wsa_out_if;
  import wsa_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot_out;
  value_t  old_value;
  logic    stop;

  modport source (output valid, status, slot_out, old_value, stop, input ready);
  modport sink   (input valid, status, slot_out, old_value, stop, output ready);
endinterface

>>> design/watchpoint_slot_allocator_unit.sv
// watchpoint_slot_allocator_unit: pool of watch slots with a lifo free list
// depends on wsa_pkg and the channel interfaces in wsa_if.sv

// In a command transaction, the accept edge issues the reads of the free-stack
// memory and the watch-value memory; the execute edge, which waits while the
// result register holds a result not yet taken, executes, writes back and loads
// the result register. Only after that is the input ready again, so a new
// command waits until the last has executed. A result waiting in the output
// register does not block the next accept. The free stack needs no clearing
// pass after reset: a low-water mark of the free count tells never-written
// stack entries, which read as their reset slot numbers. Active marks sit in
// flip-flops that reset clears; watch values are written on allocate.
module watchpoint_slot_allocator_unit #(
  parameter int POOL_SIZE = 32
) (
  input  logic clk,
  input  logic rst_n,
  wsa_in_if.sink    in_ch,
  wsa_out_if.source out_ch
);
  import wsa_pkg::*;

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int NW = (IW > SLOT_W) ? IW : SLOT_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  // control state
  logic     state_r, state_nxt;
  cnt_t     free_count_r, free_count_nxt;
  cnt_t     low_mark_r, low_mark_nxt;
  logic [POOL_SIZE-1:0] active_r, active_nxt;

  // captured command
  cmd_t   cmd_r;
  slot_t  num_r;
  value_t val_r;
  logic   ok_r;

  // memories and registered read data
  idx_t   stk_mem [POOL_SIZE];
  value_t val_mem [POOL_SIZE];
  idx_t   stk_rd_r;
  value_t val_rd_r;

  // result register
  logic    out_valid_r;
  status_t status_r, status_nxt;
  slot_t   slot_r, slot_nxt;
  value_t  old_r, old_nxt;
  logic    stop_r, stop_nxt;

  logic accept, exec_go;
  logic stk_we, val_we;
  idx_t stk_waddr, val_waddr;
  idx_t stk_wdata;
  value_t val_wdata;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // read addresses at accept time
  cnt_t   cnt_m1;
  idx_t   stk_raddr;
  logic [NW-1:0] in_num_ext;
  idx_t   val_raddr;
  assign cnt_m1     = free_count_r - cnt_t'(1);
  assign stk_raddr  = cnt_m1[IW-1:0];
  assign in_num_ext = NW'(in_ch.entry_number);
  assign val_raddr  = in_num_ext[IW-1:0];

  // execute-side decode
  logic [NW-1:0] num_ext;
  idx_t   num_idx;
  logic   num_active;
  idx_t   top_idx;
  idx_t   pop_slot;
  logic [NW-1:0] pop_ext;
  assign num_ext    = NW'(num_r);
  assign num_idx    = num_ext[IW-1:0];
  assign num_active = (32'(num_ext) < POOL_SIZE) && active_r[num_idx];
  assign top_idx    = cnt_m1[IW-1:0];
  // never-written stack entries hold their reset slot number
  assign pop_slot   = (CW'(top_idx) < low_mark_r) ? (idx_t'(POOL_SIZE - 1) - top_idx)
                                                 : stk_rd_r;
  assign pop_ext    = NW'(pop_slot);

  // execute: modify state and form the result
  always_comb begin
    state_nxt      = state_r;
    free_count_nxt = free_count_r;
    low_mark_nxt   = low_mark_r;
    active_nxt     = active_r;
    status_nxt     = ST_DONE;
    slot_nxt       = '0;
    old_nxt        = '0;
    stop_nxt       = 1'b0;
    stk_we         = 1'b0;
    stk_waddr      = free_count_r[IW-1:0];
    stk_wdata      = num_idx;
    val_we         = 1'b0;
    val_waddr      = num_idx;
    val_wdata      = val_r;
    if (accept) begin
      state_nxt = S_EXEC;
    end
    if (exec_go) begin
      state_nxt = S_IDLE;
      case (cmd_r)
        CMD_ALLOC: begin
          if (!ok_r) begin
            status_nxt = ST_BAD_VALUE;
          end else if (free_count_r == '0) begin
            status_nxt = ST_FULL;
          end else begin
            free_count_nxt = cnt_m1;
            if (cnt_m1 < low_mark_r) begin
              low_mark_nxt = cnt_m1;
            end
            active_nxt[pop_slot] = 1'b1;
            slot_nxt  = pop_ext[SLOT_W-1:0];
            val_we    = 1'b1;
            val_waddr = pop_slot;
          end
        end
        CMD_FREE: begin
          slot_nxt = num_r;
          if (!num_active) begin
            status_nxt = ST_NOT_ACTIVE;
          end else begin
            active_nxt[num_idx] = 1'b0;
            stk_we         = 1'b1;
            free_count_nxt = free_count_r + cnt_t'(1);
          end
        end
        CMD_CHECK: begin
          slot_nxt = num_r;
          if (!num_active) begin
            status_nxt = ST_NOT_ACTIVE;
          end else if (!ok_r) begin
            status_nxt = ST_NO_EVAL;
            stop_nxt   = 1'b1;
          end else if (val_r != val_rd_r) begin
            status_nxt = ST_CHANGED;
            old_nxt    = val_rd_r;
            stop_nxt   = 1'b1;
            val_we     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= cnt_t'(POOL_SIZE);
      low_mark_r   <= cnt_t'(POOL_SIZE);
      active_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      low_mark_r   <= low_mark_nxt;
      active_r     <= active_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured transaction and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      num_r <= in_ch.entry_number;
      val_r <= in_ch.new_value;
      ok_r  <= in_ch.value_ok;
    end
    if (exec_go) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      old_r    <= old_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // free-stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (accept) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // watch-value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (accept) begin
      val_rd_r <= val_mem[val_raddr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.slot_out  = slot_r;
  assign out_ch.old_value = old_r;
  assign out_ch.stop      = stop_r;

  // every slot is either active or on the free list
  a_pool_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    (32'($countones(active_r)) + 32'(free_count_r)) == POOL_SIZE)
    else $error("slot count mismatch between active marks and free list");

  // low-water mark never above the free count
  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
    low_mark_r <= free_count_r)
    else $error("free-stack low-water mark above free count");

  // an accepted transaction always goes to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted transaction did not reach execute");

  // a pool-full result only when the free list was empty
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && (status_nxt == ST_FULL)) |-> (free_count_r == '0))
    else $error("pool-full status with free slots left");

endmodule
